// File: hw/rtl/tlv_stream_parser_macros.svh
// Assertion macros for the TLV stream parser.
// Included by RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef TLV_STREAM_PARSER_MACROS_SVH
`define TLV_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlv_stream_parser check failed");

// Next-cycle implication, checked outside reset.
`define TSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlv_stream_parser check failed");

`endif

// File: hw/rtl/tsp_pkg.sv
// Package for the TLV stream parser: parse phases and the result record type.
// No dependencies; used by all parser modules.
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

    // Parser phase within a record.
    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_LENLO = 2'd1,
        PH_LENHI = 2'd2,
        PH_VALUE = 2'd3
    } tsp_phase_t;

    // One result beat.
    typedef struct packed {
        logic [7:0]  rec_type;
        logic [15:0] rec_len;
        logic [7:0]  value_byte;
        logic        has_byte;
        logic        rec_end;
        logic        buf_end;
        logic        status;
    } tsp_result_t;

    // Status codes at buffer end.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_TRUNCATED = 1'b1;

endpackage

`default_nettype wire

// File: hw/rtl/tsp_ifs.sv
// Valid/ready channel interfaces for the TLV stream parser: byte input and result output.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       buf_last;

    modport source (output valid, output in_byte, output buf_last, input ready);
    modport sink   (input valid, input in_byte, input buf_last, output ready);
endinterface

interface tsp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rec_type;
    logic [15:0] rec_len;
    logic [7:0]  value_byte;
    logic        has_byte;
    logic        rec_end;
    logic        buf_end;
    logic        status;

    modport source (output valid, output rec_type, output rec_len, output value_byte,
                    output has_byte, output rec_end, output buf_end, output status,
                    input ready);
    modport sink   (input valid, input rec_type, input rec_len, input value_byte,
                    input has_byte, input rec_end, input buf_end, input status,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tsp_parse.sv
// Record parser: phase machine, held header fields and value byte counter.
// Produces at most one result per accepted beat. Depends on tsp_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "tlv_stream_parser_macros.svh"

module tsp_parse
    import tsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_fire,
    input  wire logic [7:0]  in_byte,
    input  wire logic        buf_last,
    output logic             res_valid,
    output tsp_result_t      res
);

    tsp_phase_t  phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] len_full;
    logic [15:0] left_dec;
    logic        val_done;

    // Header length as it stands once the high byte arrives.
    assign len_full = {in_byte, len_reg[7:0]};
    assign left_dec = (left_reg != 16'd0) ? left_reg - 16'd1 : 16'd0;
    assign val_done = (left_dec == 16'd0);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_TYPE:
            begin
                phase_next = buf_last ? PH_TYPE : PH_LENLO;
            end
            PH_LENLO:
            begin
                phase_next = buf_last ? PH_TYPE : PH_LENHI;
            end
            PH_LENHI:
            begin
                phase_next = (buf_last || len_full == 16'd0) ? PH_TYPE : PH_VALUE;
            end
            PH_VALUE:
            begin
                phase_next = (buf_last || val_done) ? PH_TYPE : PH_VALUE;
            end
            default:
            begin
                phase_next = PH_TYPE;
            end
        endcase
    end

    // Held fields, counter and the result beat.
    always_comb
    begin
        type_next = type_reg;
        len_next  = len_reg;
        left_next = left_reg;
        res_valid = 1'b0;
        res       = '0;
        unique case (phase_reg)
            PH_TYPE:
            begin
                type_next = in_byte;
                if (buf_last)
                begin
                    left_next  = 16'd0;
                    res_valid  = 1'b1;
                    res.buf_end = 1'b1;
                    res.status  = STATUS_TRUNCATED;
                end
            end
            PH_LENLO:
            begin
                len_next = {8'd0, in_byte};
                if (buf_last)
                begin
                    left_next  = 16'd0;
                    res_valid  = 1'b1;
                    res.buf_end = 1'b1;
                    res.status  = STATUS_TRUNCATED;
                end
            end
            PH_LENHI:
            begin
                len_next = len_full;
                if (buf_last)
                begin
                    left_next  = 16'd0;
                    res_valid  = 1'b1;
                    res.buf_end = 1'b1;
                    res.status  = STATUS_TRUNCATED;
                end
                else if (len_full == 16'd0)
                begin
                    // Empty record in mid-buffer.
                    left_next    = 16'd0;
                    res_valid    = 1'b1;
                    res.rec_type = type_reg;
                    res.rec_end  = 1'b1;
                end
                else
                begin
                    left_next = len_full;
                end
            end
            PH_VALUE:
            begin
                res_valid      = 1'b1;
                res.rec_type   = type_reg;
                res.rec_len    = len_reg;
                res.value_byte = in_byte;
                res.has_byte   = 1'b1;
                res.rec_end    = val_done;
                res.buf_end    = buf_last;
                res.status     = (buf_last && !val_done) ? STATUS_TRUNCATED : STATUS_OK;
                left_next      = (buf_last || val_done) ? 16'd0 : left_dec;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // State registers advance only on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            type_reg  <= 8'd0;
            len_reg   <= 16'd0;
            left_reg  <= 16'd0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
        end
    end

    // Inside a value there is always at least one byte still expected.
    `TSP_ASSERT_NOW(a_value_has_left, phase_reg == PH_VALUE, left_reg != 16'd0)

endmodule

`default_nettype wire

// File: hw/rtl/tsp_out_stage.sv
// Output register with one skid entry for the parser's result beats.
// Depends on tsp_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "tlv_stream_parser_macros.svh"

module tsp_out_stage
    import tsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire tsp_result_t push_data,
    output logic             can_accept,
    output logic             out_valid,
    input  wire logic        out_ready,
    output tsp_result_t      out_data
);

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    tsp_result_t main_reg, main_next;
    tsp_result_t skid_reg, skid_next;
    logic        pop;

    assign pop        = main_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    // Main and skid entry update.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    `TSP_ASSERT_NOW(a_skid_behind_main, skid_valid_reg, main_valid_reg)
    `TSP_ASSERT_NEXT(a_drain_empties,
        main_valid_reg && out_ready && !skid_valid_reg && !push, !main_valid_reg)
    `TSP_ASSERT_NEXT(a_fill_empty_main,
        push && !skid_valid_reg && !main_valid_reg, main_valid_reg && !skid_valid_reg)

endmodule

`default_nettype wire

// File: hw/rtl/tlv_stream_parser.sv
// Top level of the TLV stream parser: record parser feeding a skid-buffered output register.
// Depends on tsp_pkg, tsp_ifs, tsp_parse and tsp_out_stage.
//
//   Channel      Dir  Payload                                          Beat
//   bytes_in     in   in_byte, buf_last                                one buffer byte
//   records_out  out  rec_type, rec_len, value_byte, has_byte,         zero or one per
//                     rec_end, buf_end, status                         input byte
//
// One input byte is taken per cycle while the skid entry is empty; its result, if any,
// enters the output register, or the skid entry when the output stalls. The phase machine
// and 16-bit byte counter update once per accepted byte. Header bytes give no result beat,
// but at a buffer end or for an empty record. When the output stalls, the output register
// and one skid entry hold two results; input stops only once the skid entry is full.
// Reset (rst_n low, asynchronous) returns the parser to expecting a type byte.
`timescale 1ns / 1ps
`default_nettype none

module tlv_stream_parser
    import tsp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tsp_in_if.sink     bytes_in,
    tsp_out_if.source  records_out
);

    logic        can_accept;
    logic        in_fire;
    logic        res_valid;
    tsp_result_t res;
    tsp_result_t out_data;

    assign bytes_in.ready = can_accept;
    assign in_fire        = bytes_in.valid && can_accept;

    // Record parser.
    tsp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_byte   (bytes_in.in_byte),
        .buf_last  (bytes_in.buf_last),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register and skid entry.
    tsp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_fire && res_valid),
        .push_data  (res),
        .can_accept (can_accept),
        .out_valid  (records_out.valid),
        .out_ready  (records_out.ready),
        .out_data   (out_data)
    );

    // Result fields onto the output channel.
    assign records_out.rec_type   = out_data.rec_type;
    assign records_out.rec_len    = out_data.rec_len;
    assign records_out.value_byte = out_data.value_byte;
    assign records_out.has_byte   = out_data.has_byte;
    assign records_out.rec_end    = out_data.rec_end;
    assign records_out.buf_end    = out_data.buf_end;
    assign records_out.status     = out_data.status;

endmodule

`default_nettype wire
